>>> sv/asts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asts_pkg: shared types and constants of the additive sine tone synthesizer
// widths, register indexes, sequencer states and the quarter-wave sine rom
// ----------------------------------------------------------------------------
package asts_pkg;

	localparam int MAX_TONES  = 4;
	localparam int PHASE_BITS = 24;
	localparam int TABLE_BITS = 10;
	localparam int QUART_BITS = TABLE_BITS - 2;
	localparam int QUART_LEN  = 1 << QUART_BITS;
	localparam int ZSHIFT     = 14 - QUART_BITS;
	localparam int AMP_W      = 16;
	localparam int SINE_W     = 16;
	localparam int MAG_W      = 15;
	localparam int PROD_W     = SINE_W + AMP_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int ABS_W      = PROD_W;
	localparam int CLAMP_W    = 29;
	localparam int FULL_W     = 15;
	localparam int PCM_W      = 16;
	localparam int CNT_W      = 3;
	localparam int IDX_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [MAG_W-1:0]   SINE_PEAK  = MAG_W'(1 << 14);
	localparam logic [CLAMP_W-1:0] CLAMP_MAX  = CLAMP_W'(1 << 28);
	localparam logic [FULL_W-1:0]  FULL_SCALE = FULL_W'(32767);
	localparam logic [ABS_W:0]     RECIP3     = 33'h0AAAAAAAB;
	localparam int                 RECIP3_SH  = 33;
	localparam logic [IDX_W-1:0]   SAMPLES_RST = IDX_W'(48000);

	localparam int SIN_A = 25736;
	localparam int SIN_B = 10512;
	localparam int SIN_C = 1160;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE_COUNT   = 3'd0,
		REG_TONE_A       = 3'd1,
		REG_TONE_B       = 3'd2,
		REG_TONE_C       = 3'd3,
		REG_TONE_D       = 3'd4,
		REG_SAMPLE_COUNT = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROT  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [PHASE_BITS-1:0] phase;
		logic [PHASE_BITS-1:0] step;
		logic signed [AMP_W-1:0] amp;
	} tone_t;

	typedef struct packed {
		logic shift;
		logic adv;
		logic zero;
		logic clr;
		logic wr;
	} cell_ctl_t;

	typedef struct packed {
		logic issue;
		logic clear;
	} mac_ctl_t;

	typedef logic [MAG_W-1:0] sine_rom_t [QUART_LEN];

	// first quadrant of the sine, magnitude in q1.14, built at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		int unsigned t;
		int unsigned t2;
		int unsigned r;
		for (int j = 0; j < QUART_LEN; j++) begin
			t  = j << ZSHIFT;
			t2 = (t * t) >> 14;
			r  = SIN_B - ((SIN_C * t2) >> 14);
			r  = SIN_A - ((r * t2) >> 14);
			rom[j] = MAG_W'((r * t) >> 14);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> sv/asts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asts_if: handshake channels of the tone synthesizer
// configuration writes, sample ticks in and pcm samples out
// ----------------------------------------------------------------------------
interface asts_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [asts_pkg::CFG_IDX_W-1:0]      index;
	logic [asts_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface asts_in_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, restart, input ready);
	modport sink (input valid, restart, output ready);
endinterface

interface asts_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [asts_pkg::PCM_W-1:0]   pcm_sample;
	logic                                last;
	modport source (output valid, pcm_sample, last, input ready);
	modport sink (input valid, pcm_sample, last, output ready);
endinterface

>>> sv/asts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asts_cell: one tone of the ring
// holds phase, step and amplitude, passes them to its neighbor on a shift
// ----------------------------------------------------------------------------
module asts_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  asts_pkg::cell_ctl_t                 ctl,
	input  logic [asts_pkg::CFG_DATA_W-1:0]     wr_data,
	input  asts_pkg::tone_t                     nb_in,
	output asts_pkg::tone_t                     cur,
	output asts_pkg::tone_t                     nb_out
);

	logic [asts_pkg::PHASE_BITS-1:0]   phase_q;
	logic [asts_pkg::PHASE_BITS-1:0]   step_q;
	logic signed [asts_pkg::AMP_W-1:0] amp_q;
	logic [asts_pkg::PHASE_BITS-1:0]   pass_phase;

	// the ring head advances the phase on its way round, or zeroes it at burst end
	always_comb begin
		pass_phase = phase_q;
		if (ctl.adv) begin
			pass_phase = ctl.zero ? '0 : phase_q + step_q;
		end
	end

	assign cur    = '{phase: phase_q, step: step_q, amp: amp_q};
	assign nb_out = '{phase: pass_phase, step: step_q, amp: amp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			amp_q   <= '0;
		end else begin
			if (ctl.clr) begin
				phase_q <= '0;
			end else if (ctl.shift) begin
				phase_q <= nb_in.phase;
			end
			if (ctl.wr) begin
				step_q <= wr_data[asts_pkg::PHASE_BITS-1:0];
				amp_q  <= wr_data[asts_pkg::PHASE_BITS +: asts_pkg::AMP_W];
			end else if (ctl.shift) begin
				step_q <= nb_in.step;
				amp_q  <= nb_in.amp;
			end
		end
	end

endmodule

>>> sv/asts_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asts_mac: shared sine lookup, amplitude multiply and accumulate
// one tone a cycle from the ring head, three stages
// ----------------------------------------------------------------------------
module asts_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  asts_pkg::mac_ctl_t                    ctl,
	input  logic [asts_pkg::PHASE_BITS-1:0]       phase,
	input  logic signed [asts_pkg::AMP_W-1:0]     amp,
	output logic signed [asts_pkg::ACC_W-1:0]     acc
);

	logic [asts_pkg::TABLE_BITS-1:0]    tidx;
	logic [1:0]                         quad;
	logic [asts_pkg::QUART_BITS-1:0]    low;
	logic [asts_pkg::QUART_BITS-1:0]    addr;
	logic [asts_pkg::MAG_W-1:0]         mag;
	logic signed [asts_pkg::SINE_W-1:0] sine;

	logic signed [asts_pkg::SINE_W-1:0] sin_s1;
	logic signed [asts_pkg::AMP_W-1:0]  amp_s1;
	logic                               vld_s1;
	logic signed [asts_pkg::PROD_W-1:0] prod_s2;
	logic                               vld_s2;
	logic signed [asts_pkg::ACC_W-1:0]  acc_q;

	// quarter-wave fold: odd quadrants mirror, upper half negates
	assign tidx = phase[asts_pkg::PHASE_BITS-1 -: asts_pkg::TABLE_BITS];
	assign quad = tidx[asts_pkg::TABLE_BITS-1 -: 2];
	assign low  = tidx[asts_pkg::QUART_BITS-1:0];

	always_comb begin
		addr = quad[0] ? asts_pkg::QUART_BITS'(-low) : low;
		if (quad[0] && (low == '0)) begin
			mag = asts_pkg::SINE_PEAK;
		end else begin
			mag = asts_pkg::SINE_ROM[addr];
		end
		sine = quad[1] ? -asts_pkg::SINE_W'(mag) : asts_pkg::SINE_W'(mag);
	end

	always_ff @(posedge clk) begin
		sin_s1  <= sine;
		amp_s1  <= amp;
		prod_s2 <= sin_s1 * amp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + asts_pkg::ACC_W'(prod_s2);
			end
		end
	end

	assign acc = acc_q;

endmodule

>>> sv/asts_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asts_norm: mean over the tones, clamp and scale to pcm
// magnitude, divide by tone count, clamp to full scale, multiply by 32767
// ----------------------------------------------------------------------------
module asts_norm (
	input  logic                                clk,
	input  logic signed [asts_pkg::ACC_W-1:0]   acc,
	input  logic [asts_pkg::CNT_W-1:0]          tones,
	output logic signed [asts_pkg::PCM_W-1:0]   pcm
);

	logic [asts_pkg::ABS_W-1:0]   mag_s1;
	logic                         neg_s1;
	logic [asts_pkg::CLAMP_W-1:0] q_s2;
	logic                         neg_s2;

	logic [asts_pkg::ACC_W-1:0]   acc_abs;
	logic [2*asts_pkg::ABS_W:0]   div3_full;
	logic [asts_pkg::ABS_W-1:0]   quot;
	logic [asts_pkg::CLAMP_W+asts_pkg::FULL_W-1:0] scaled_full;
	logic [asts_pkg::PCM_W-1:0]   scaled;

	assign acc_abs = acc[asts_pkg::ACC_W-1] ? asts_pkg::ACC_W'(-acc) : asts_pkg::ACC_W'(acc);

	// division by three through the reciprocal, exact for 32-bit magnitudes
	always_comb begin
		div3_full = (2*asts_pkg::ABS_W+1)'(mag_s1) * (2*asts_pkg::ABS_W+1)'(asts_pkg::RECIP3);
		unique case (tones)
			3'd1:    quot = mag_s1;
			3'd2:    quot = mag_s1 >> 1;
			3'd3:    quot = asts_pkg::ABS_W'(div3_full >> asts_pkg::RECIP3_SH);
			default: quot = mag_s1 >> 2;
		endcase
	end

	always_ff @(posedge clk) begin
		neg_s1 <= acc[asts_pkg::ACC_W-1];
		mag_s1 <= acc_abs[asts_pkg::ABS_W-1:0];
		neg_s2 <= neg_s1;
		if (quot > asts_pkg::ABS_W'(asts_pkg::CLAMP_MAX)) begin
			q_s2 <= asts_pkg::CLAMP_MAX;
		end else begin
			q_s2 <= quot[asts_pkg::CLAMP_W-1:0];
		end
	end

	always_comb begin
		scaled_full = (asts_pkg::CLAMP_W+asts_pkg::FULL_W)'(q_s2)
			* (asts_pkg::CLAMP_W+asts_pkg::FULL_W)'(asts_pkg::FULL_SCALE);
		scaled = scaled_full[asts_pkg::CLAMP_W+asts_pkg::FULL_W-1 -: asts_pkg::PCM_W];
		pcm    = neg_s2 ? -scaled : scaled;
	end

endmodule

>>> sv/additive_sine_tone_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_sine_tone_synth: four-tone additive sine synthesizer
// one pcm sample per tick, tones held in a rotating ring of cells
// ----------------------------------------------------------------------------
//
// channel     role   payload                          accepted when
// cfg         sink   index[2:0], data[39:0]           valid & ready
// sample_in   sink   restart                          valid & ready
// sample_out  source pcm_sample[15:0] signed, last    valid & ready
//
// an item passes through the accept, four ring shifts through the shared
// sine rom and multiplier, the multiply-accumulate drain and
// mean/clamp/scale, then the load of the output register
// reset clears phases, sample index, tone registers and the sequencer;
// tone_count resets to 1 and sample_count to 48000
// a stalled output holds the finished sample; the next item is accepted
// meanwhile and waits in the last step until the output register frees
//
module additive_sine_tone_synth (
	input  logic           clk,
	input  logic           arst_n,
	asts_cfg_if.sink       cfg,
	asts_in_if.sink        sample_in,
	asts_out_if.source     sample_out
);

	// configuration
	logic [asts_pkg::CNT_W-1:0]  tone_count_q;
	logic [asts_pkg::IDX_W-1:0]  sample_count_q;
	logic                        cfg_wr;

	// sequencer and burst position
	asts_pkg::state_t            state_q;
	logic [1:0]                  cnt_q;
	logic [asts_pkg::IDX_W-1:0]  idx_q;
	logic                        last_q;
	logic                        accept;
	logic [asts_pkg::CNT_W-1:0]  n_eff;
	logic [asts_pkg::IDX_W-1:0]  end_idx;
	logic [asts_pkg::IDX_W-1:0]  cur_idx;
	logic                        cur_last;

	// output register
	logic                                out_valid_q;
	logic signed [asts_pkg::PCM_W-1:0]   pcm_q;
	logic                                out_last_q;
	logic                                out_load;

	// ring of cells and shared datapath
	asts_pkg::tone_t             cell_cur [asts_pkg::MAX_TONES];
	asts_pkg::tone_t             cell_nb  [asts_pkg::MAX_TONES];
	asts_pkg::mac_ctl_t          mac_ctl;
	logic signed [asts_pkg::ACC_W-1:0] acc;
	logic signed [asts_pkg::PCM_W-1:0] pcm;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// writes to unlisted indexes fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_count_q   <= asts_pkg::CNT_W'(1);
			sample_count_q <= asts_pkg::SAMPLES_RST;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				asts_pkg::REG_TONE_COUNT:   tone_count_q   <= cfg.data[asts_pkg::CNT_W-1:0];
				asts_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg.data[asts_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// zero tones counts as one, more than the ring holds saturates
	always_comb begin
		if (tone_count_q == '0) begin
			n_eff = asts_pkg::CNT_W'(1);
		end else if (tone_count_q > asts_pkg::CNT_W'(asts_pkg::MAX_TONES)) begin
			n_eff = asts_pkg::CNT_W'(asts_pkg::MAX_TONES);
		end else begin
			n_eff = tone_count_q;
		end
	end

	// an empty burst behaves as one sample long, so every sample is last
	assign end_idx  = (sample_count_q == '0) ? '0 : sample_count_q - 1'b1;
	assign cur_idx  = sample_in.restart ? '0 : idx_q;
	assign cur_last = cur_idx >= end_idx;

	assign sample_in.ready = (state_q == asts_pkg::ST_IDLE);
	assign accept          = sample_in.valid && sample_in.ready;
	assign out_load        = (state_q == asts_pkg::ST_FIN) && (!out_valid_q || sample_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asts_pkg::ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				asts_pkg::ST_IDLE: begin
					if (accept) begin
						// index wraps after the last sample; phases zero on the ring pass
						last_q  <= cur_last;
						idx_q   <= cur_last ? '0 : cur_idx + 1'b1;
						cnt_q   <= '0;
						state_q <= asts_pkg::ST_ROT;
					end
				end
				asts_pkg::ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= asts_pkg::ST_WAIT;
					end
				end
				asts_pkg::ST_WAIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= asts_pkg::ST_FIN;
					end
				end
				asts_pkg::ST_FIN: begin
					if (out_load) begin
						state_q <= asts_pkg::ST_IDLE;
					end
				end
				default: state_q <= asts_pkg::ST_IDLE;
			endcase
		end
	end

	// cell i sits at the ring head on shift i; after four shifts every tone is home
	generate
		for (genvar i = 0; i < asts_pkg::MAX_TONES; i++) begin : g_cell
			localparam int NXT = (i + 1) % asts_pkg::MAX_TONES;
			asts_pkg::cell_ctl_t ctl;

			assign ctl.shift = (state_q == asts_pkg::ST_ROT);
			assign ctl.adv   = (i == 0);
			assign ctl.zero  = last_q;
			assign ctl.clr   = accept && sample_in.restart;
			assign ctl.wr    = cfg_wr && (cfg.index ==
				asts_pkg::CFG_IDX_W'(asts_pkg::REG_TONE_A) + asts_pkg::CFG_IDX_W'(i));

			asts_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.wr_data (cfg.data),
				.nb_in   (cell_nb[NXT]),
				.cur     (cell_cur[i]),
				.nb_out  (cell_nb[i])
			);
		end
	endgenerate

	// only the first n_eff tones reach the accumulator
	assign mac_ctl.issue = (state_q == asts_pkg::ST_ROT) && ({1'b0, cnt_q} < n_eff);
	assign mac_ctl.clear = accept;

	asts_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.phase  (cell_cur[0].phase),
		.amp    (cell_cur[0].amp),
		.acc    (acc)
	);

	asts_norm u_norm (
		.clk   (clk),
		.acc   (acc),
		.tones (n_eff),
		.pcm   (pcm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (sample_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pcm_q      <= pcm;
			out_last_q <= last_q;
		end
	end

	assign sample_out.valid      = out_valid_q;
	assign sample_out.pcm_sample = pcm_q;
	assign sample_out.last       = out_last_q;

`ifndef ASSERT_OFF
	a_accept_starts_ring: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == asts_pkg::ST_ROT) && (cnt_q == 2'd0))
		else $error("accepted item did not start the ring rotation");

	a_four_shifts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == asts_pkg::ST_ROT) && (cnt_q == 2'd3) |=> (state_q == asts_pkg::ST_WAIT))
		else $error("ring rotation did not end after four shifts");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == asts_pkg::ST_FIN)
		else $error("output loaded outside the final step");

	a_last_wraps_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == asts_pkg::ST_FIN) && last_q |-> (idx_q == '0))
		else $error("sample index not wrapped after the last sample");
`endif

endmodule

>>> tb/additive_sine_tone_synth_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_sine_tone_synth_tb: self-checking bench of the tone synthesizer
// a scoreboard class predicts every pcm sample from its own model of the
// phase accumulators, sine approximation, mean, clamp and burst counter;
// tasks write registers and send sample ticks, a sink process takes samples
// with random back-pressure, including one long hold-off that fills the block
// ----------------------------------------------------------------------------
module additive_sine_tone_synth_tb;

	// sine polynomial and scaling used by the prediction
	localparam int unsigned POLY_A   = 25736;
	localparam int unsigned POLY_B   = 10512;
	localparam int unsigned POLY_C   = 1160;
	localparam longint      PCM_FULL = 32767;
	localparam longint      Q28_ONE  = 64'sd1 << 28;

	// register indexes that decode to nothing
	localparam logic [asts_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [asts_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int RANDOM_TICKS = 1800;
	localparam int LONG_HOLD    = 320;   // receiver hold-off that fills the block
	localparam int QUIET_LIMIT  = 4000;  // cycles without any accepted item
	localparam int TAIL_CYCLES  = 40;    // settle time after the last sample
	localparam int REPORT_CAP   = 40;    // mismatch lines printed at most

	typedef struct {
		logic signed [asts_pkg::PCM_W-1:0] pcm;
		logic                              last;
	} pcm_item_t;

	// ------------------------------------------------------------------
	// scoreboard: own copy of the registers and run state, queue of
	// expected samples in order of acceptance
	// ------------------------------------------------------------------
	class pcm_predictor;
		logic [asts_pkg::CNT_W-1:0]      tone_count;
		logic [asts_pkg::CFG_DATA_W-1:0] tone_word [asts_pkg::MAX_TONES];
		logic [asts_pkg::IDX_W-1:0]      sample_count;
		logic [asts_pkg::PHASE_BITS-1:0] phase [asts_pkg::MAX_TONES];
		logic [asts_pkg::IDX_W-1:0]      sample_idx;
		pcm_item_t                       pending [$];
		int                              errors;

		function new();
			tone_count   = asts_pkg::CNT_W'(1);
			sample_count = asts_pkg::IDX_W'(48000);
			foreach (tone_word[i]) tone_word[i] = '0;
			errors = 0;
			clear_run();
		endfunction

		function void clear_run();
			foreach (phase[i]) phase[i] = '0;
			sample_idx = '0;
		endfunction

		function void note_write(logic [asts_pkg::CFG_IDX_W-1:0] idx,
			logic [asts_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				asts_pkg::REG_TONE_COUNT:   tone_count = val[asts_pkg::CNT_W-1:0];
				asts_pkg::REG_TONE_A:       tone_word[0] = val;
				asts_pkg::REG_TONE_B:       tone_word[1] = val;
				asts_pkg::REG_TONE_C:       tone_word[2] = val;
				asts_pkg::REG_TONE_D:       tone_word[3] = val;
				asts_pkg::REG_SAMPLE_COUNT: sample_count = val[asts_pkg::IDX_W-1:0];
				default: ;
			endcase
		endfunction

		// q1.14 sine of a table entry, folded by quadrant onto the polynomial
		function int sine_q14(logic [asts_pkg::TABLE_BITS-1:0] k);
			logic [15:0] u;
			int unsigned z;
			int unsigned t2;
			int unsigned r;
			int unsigned mag;
			u = {k, {(16 - asts_pkg::TABLE_BITS){1'b0}}};
			z = 32'(u[13:0]);
			if (u[14]) z = 16384 - z;
			t2  = (z * z) >> 14;
			r   = POLY_B - ((POLY_C * t2) >> 14);
			r   = POLY_A - ((r * t2) >> 14);
			mag = (r * z) >> 14;
			return u[15] ? -int'(mag) : int'(mag);
		endfunction

		function void take_tick(logic restart);
			int unsigned n;
			int          i;
			longint      acc;
			longint      mean;
			longint      mag;
			logic [asts_pkg::IDX_W-1:0] end_idx;
			pcm_item_t   want;
			if (restart) clear_run();
			// zero counts as one tone, anything above four counts as four
			if (tone_count == 0) n = 1;
			else if (tone_count > asts_pkg::MAX_TONES) n = asts_pkg::MAX_TONES;
			else n = 32'(tone_count);
			acc = 0;
			for (i = 0; i < n; i++)
				acc += longint'(sine_q14(phase[i][asts_pkg::PHASE_BITS-1 -: asts_pkg::TABLE_BITS]))
					* longint'($signed(tone_word[i][asts_pkg::CFG_DATA_W-1:asts_pkg::PHASE_BITS]));
			mean = acc / longint'(n);
			if (mean > Q28_ONE) mean = Q28_ONE;
			if (mean < -Q28_ONE) mean = -Q28_ONE;
			mag = (mean < 0) ? -mean : mean;
			mag = (mag * PCM_FULL) >> 28;
			want.pcm = asts_pkg::PCM_W'((mean < 0) ? -mag : mag);
			// a zero burst length behaves as one, so every sample ends a burst
			end_idx   = (sample_count == 0) ? '0 : sample_count - 1'b1;
			want.last = (sample_idx >= end_idx);
			pending.push_back(want);
			if (want.last) begin
				clear_run();
			end else begin
				for (i = 0; i < asts_pkg::MAX_TONES; i++)
					phase[i] += tone_word[i][asts_pkg::PHASE_BITS-1:0];
				sample_idx += 1'b1;
			end
		endfunction

		function void match_sample(logic signed [asts_pkg::PCM_W-1:0] pcm, logic last);
			pcm_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t ns: unexpected sample, expected none, got pcm %0d last %0b",
						$time, pcm, last);
				return;
			end
			want = pending.pop_front();
			if (pcm !== want.pcm) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t ns: pcm_sample expected %0d got %0d", $time, want.pcm, pcm);
			end
			if (last !== want.last) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t ns: last expected %0b got %0b", $time, want.last, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	asts_cfg_if cfg_ch ();
	asts_in_if  tick_ch ();
	asts_out_if pcm_ch ();

	additive_sine_tone_synth dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.sample_in  (tick_ch),
		.sample_out (pcm_ch)
	);

	pcm_predictor book = new();

	int idle_mode;      // 0 no gaps, 1 light, 2 heavy
	int hold_requests;  // bumped by the stimulus to ask the sink for a long hold
	int ticks_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// gap length in cycles: mostly short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		case (idle_mode)
			0: return 0;
			1: begin
				if (roll < 80) return 0;
				if (roll < 97) return $urandom_range(1, 3);
				return $urandom_range(10, 40);
			end
			default: begin
				if (roll < 50) return 0;
				if (roll < 90) return $urandom_range(1, 5);
				return $urandom_range(10, 60);
			end
		endcase
	endfunction

	function automatic logic [asts_pkg::CFG_DATA_W-1:0] tone_word_of(
		logic [asts_pkg::AMP_W-1:0] amp, logic [asts_pkg::PHASE_BITS-1:0] step);
		return {amp, step};
	endfunction

	// random value for one register, weighted toward the interesting corners
	function automatic logic [asts_pkg::CFG_DATA_W-1:0] pick_value(
		logic [asts_pkg::CFG_IDX_W-1:0] idx);
		int roll;
		logic [asts_pkg::AMP_W-1:0]      amp;
		logic [asts_pkg::PHASE_BITS-1:0] step;
		roll = $urandom_range(0, 99);
		case (idx)
			asts_pkg::REG_TONE_COUNT: begin
				if (roll < 80)
					return asts_pkg::CFG_DATA_W'($urandom_range(1, asts_pkg::MAX_TONES));
				return asts_pkg::CFG_DATA_W'({$urandom(), $urandom()});
			end
			asts_pkg::REG_TONE_A, asts_pkg::REG_TONE_B,
			asts_pkg::REG_TONE_C, asts_pkg::REG_TONE_D: begin
				amp = asts_pkg::AMP_W'($urandom());
				if (roll < 15) amp = 16'h7FFF;
				else if (roll < 30) amp = 16'h8000;
				roll = $urandom_range(0, 99);
				if (roll < 50) step = asts_pkg::PHASE_BITS'($urandom_range(0, 1 << 20));
				else if (roll < 80) step = asts_pkg::PHASE_BITS'($urandom());
				else if (roll < 90) step = '0;
				else step = '1;
				return tone_word_of(amp, step);
			end
			asts_pkg::REG_SAMPLE_COUNT: begin
				// short bursts so that the wrap comes often
				if (roll < 70) return asts_pkg::CFG_DATA_W'($urandom_range(1, 64));
				if (roll < 80) return asts_pkg::CFG_DATA_W'(0);
				if (roll < 90) return asts_pkg::CFG_DATA_W'(1);
				return asts_pkg::CFG_DATA_W'({$urandom(), $urandom()});
			end
			default: return asts_pkg::CFG_DATA_W'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic write_reg(input logic [asts_pkg::CFG_IDX_W-1:0] idx,
		input logic [asts_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		book.note_write(idx, val);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one sample tick; valid stays high across back-to-back items
	task automatic send_tick(input logic restart);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (tick_ch.valid) tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid   <= 1'b1;
		tick_ch.restart <= restart;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		book.take_tick(restart);
		ticks_sent++;
	endtask

	task automatic send_ticks(input int n, input int restart_pct);
		repeat (n) send_tick($urandom_range(0, 99) < restart_pct);
	endtask

	// stop offering ticks and wait until every predicted sample has come out
	task automatic wait_all_out();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (book.pending.size() != 0) @(posedge clk);
	endtask

	// sample sink: checks each accepted sample, then decides the next ready
	initial begin : pcm_sink
		int hold;
		int served;
		hold   = 0;
		served = 0;
		pcm_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pcm_ch.valid === 1'b1 && pcm_ch.ready === 1'b1)
				book.match_sample(pcm_ch.pcm_sample, pcm_ch.last);
			if (served != hold_requests) begin
				served = hold_requests;
				hold   = LONG_HOLD;
			end else if (hold > 0) begin
				hold--;
			end else begin
				hold = pick_gap();
			end
			pcm_ch.ready <= (hold == 0);
		end
	end

	// watchdog on cycles in which no channel moves an item
	initial begin : quiet_watch
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((cfg_ch.valid && cfg_ch.ready) || (tick_ch.valid && tick_ch.ready)
				|| (pcm_ch.valid && pcm_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, quiet);
				$display("additive_sine_tone_synth_tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int n;
		int round;
		int r;
		idle_mode     = 1;
		hold_requests = 0;
		ticks_sent    = 0;
		arst_n          <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= '0;
		cfg_ch.data     <= '0;
		tick_ch.valid   <= 1'b0;
		tick_ch.restart <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: one silent tone, long burst, so zeros without last
		send_tick(1'b0);
		send_tick(1'b0);
		wait_all_out();

		// zero tone count acts as one; quarter-cycle step walks zero, peak,
		// zero, trough; restart mid-burst and the end of a five-sample burst
		write_reg(asts_pkg::REG_TONE_COUNT, asts_pkg::CFG_DATA_W'(0));
		write_reg(asts_pkg::REG_TONE_A, tone_word_of(16'h7FFF, 24'h400000));
		write_reg(asts_pkg::REG_SAMPLE_COUNT, asts_pkg::CFG_DATA_W'(5));
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		wait_all_out();

		// tone count above four saturates; all tones at -2.0 drive the mean
		// past full scale both ways, so the clamp acts
		write_reg(asts_pkg::REG_TONE_COUNT, asts_pkg::CFG_DATA_W'(7));
		write_reg(asts_pkg::REG_TONE_A, tone_word_of(16'h8000, 24'hC00000));
		write_reg(asts_pkg::REG_TONE_B, tone_word_of(16'h8000, 24'hC00000));
		write_reg(asts_pkg::REG_TONE_C, tone_word_of(16'h8000, 24'hC00000));
		write_reg(asts_pkg::REG_TONE_D, tone_word_of(16'h8000, 24'hC00000));
		write_reg(asts_pkg::REG_SAMPLE_COUNT, asts_pkg::CFG_DATA_W'(4));
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		wait_all_out();

		// burst length zero: every sample is last; writes to undecoded
		// indexes must change nothing
		write_reg(asts_pkg::REG_TONE_COUNT, asts_pkg::CFG_DATA_W'(3));
		write_reg(asts_pkg::REG_TONE_D, tone_word_of(16'h7FFF, 24'hFFFFFF));
		write_reg(asts_pkg::REG_SAMPLE_COUNT, asts_pkg::CFG_DATA_W'(0));
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_all_out();

		// three tones of mixed sign, mean truncated toward zero, longest burst
		write_reg(asts_pkg::REG_TONE_A, tone_word_of(16'h7FFF, 24'h0A3D71));
		write_reg(asts_pkg::REG_TONE_B, tone_word_of(16'h4001, 24'h123457));
		write_reg(asts_pkg::REG_TONE_C, tone_word_of(16'h8000, 24'h2F0001));
		write_reg(asts_pkg::REG_SAMPLE_COUNT, asts_pkg::CFG_DATA_W'(24'hFFFFFF));
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);

		// random part: each round rewrites some registers, then a run of ticks
		round = 0;
		while (ticks_sent < RANDOM_TICKS) begin
			wait_all_out();
			idle_mode = $urandom_range(0, 2);
			for (r = 0; r < (1 << asts_pkg::CFG_IDX_W); r++)
				if ($urandom_range(0, 99) < 60)
					write_reg(asts_pkg::CFG_IDX_W'(r), pick_value(asts_pkg::CFG_IDX_W'(r)));
			n = $urandom_range(40, 200);
			if (round == 2) begin
				// sink holds off while ticks keep coming: the block fills and
				// stalls its input
				idle_mode = 0;
				hold_requests <= hold_requests + 1;
				send_ticks(60, 5);
			end else if (round == 4) begin
				// sender pauses mid-run until everything has drained
				send_ticks(n / 2, 5);
				wait_all_out();
				send_ticks(n - n / 2, 5);
			end else begin
				send_ticks(n, 5);
			end
			round++;
		end

		wait_all_out();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.errors == 0)
			$display("additive_sine_tone_synth_tb: clean");
		else
			$display("additive_sine_tone_synth_tb: errors");
		$finish;
	end

endmodule

>>> sim.f
sv/asts_pkg.sv
sv/asts_if.sv
sv/asts_cell.sv
sv/asts_mac.sv
sv/asts_norm.sv
sv/additive_sine_tone_synth.sv
tb/additive_sine_tone_synth_tb.sv
